FILE: rtl/kar_pkg.sv
// shared constants, types and register codes for the key auto repeat block
package kar_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int TIME_BITS  = 32;
    localparam int KEY_BITS   = 2;
    localparam int CFG_BITS   = 16;
    localparam int REG_BITS   = 1;

    localparam logic [CFG_BITS-1:0] RESET_DELAY    = CFG_BITS'(500);
    localparam logic [CFG_BITS-1:0] RESET_INTERVAL = CFG_BITS'(80);

    typedef logic [REG_BITS-1:0] reg_index_t;
    localparam reg_index_t REG_REPEAT_DELAY    = 1'b0;
    localparam reg_index_t REG_REPEAT_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // events produced by one input item, one slot per key
    typedef struct packed {
        logic [NUM_KEYS-1:0]  mask;
        kind_t [NUM_KEYS-1:0] kind;
    } evt_batch_t;

endpackage

FILE: rtl/kar_if.sv
// valid/ready channel interfaces for input items and events
interface kar_in_if;
    logic                              valid;
    logic                              ready;
    logic [kar_pkg::TIME_BITS-1:0]     now_ms;
    logic [kar_pkg::NUM_KEYS-1:0]      keys_down;

    modport source (output valid, output now_ms, output keys_down, input ready);
    modport sink (input valid, input now_ms, input keys_down, output ready);
endinterface

interface kar_out_if;
    logic                              valid;
    logic                              ready;
    logic [kar_pkg::KEY_BITS-1:0]      key_index;
    logic [1:0]                        event_kind;
    logic                              last_of_run;

    modport source (output valid, output key_index, output event_kind,
                    output last_of_run, input ready);
    modport sink (input valid, input key_index, input event_kind,
                  input last_of_run, output ready);
endinterface

FILE: rtl/kar_core.sv
// per key edge detection, repeat timing and key state
module kar_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [kar_pkg::TIME_BITS-1:0]     now_ms,
    input  logic [kar_pkg::NUM_KEYS-1:0]      keys_down,
    input  logic [kar_pkg::CFG_BITS-1:0]      delay,
    input  logic [kar_pkg::CFG_BITS-1:0]      interval,
    output kar_pkg::evt_batch_t               batch
);

    logic [kar_pkg::NUM_KEYS-1:0]  prev_reg;
    logic [kar_pkg::NUM_KEYS-1:0]  armed_reg;
    logic [kar_pkg::NUM_KEYS-1:0]  armed_next;
    logic [kar_pkg::TIME_BITS-1:0] stamp_reg [kar_pkg::NUM_KEYS];
    logic [kar_pkg::NUM_KEYS-1:0]  restamp;

    always_comb
    begin
        logic [kar_pkg::TIME_BITS-1:0] elapsed;
        logic                          dly_hit;
        logic                          int_hit;
        batch      = '0;
        armed_next = armed_reg;
        restamp    = '0;
        for (int k = 0; k < kar_pkg::NUM_KEYS; k++)
        begin
            elapsed = now_ms - stamp_reg[k];
            dly_hit = elapsed >= kar_pkg::TIME_BITS'(delay);
            int_hit = elapsed >= kar_pkg::TIME_BITS'(interval);
            batch.kind[k] = kar_pkg::KIND_PRESS;
            if (keys_down[k] && !prev_reg[k])
            begin
                batch.mask[k] = 1'b1;
                restamp[k]    = 1'b1;
            end
            else if (keys_down[k])
            begin
                if (armed_reg[k] && int_hit)
                begin
                    batch.mask[k] = 1'b1;
                    batch.kind[k] = kar_pkg::KIND_REPEAT;
                    restamp[k]    = 1'b1;
                end
                else if (dly_hit)
                begin
                    // arm silently and start the interval from now
                    restamp[k]    = 1'b1;
                    armed_next[k] = 1'b1;
                end
            end
            else if (prev_reg[k])
            begin
                batch.mask[k] = 1'b1;
                batch.kind[k] = kar_pkg::KIND_RELEASE;
                armed_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            armed_reg <= '0;
            for (int k = 0; k < kar_pkg::NUM_KEYS; k++)
            begin
                stamp_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            prev_reg  <= keys_down;
            armed_reg <= armed_next;
            for (int k = 0; k < kar_pkg::NUM_KEYS; k++)
            begin
                if (restamp[k])
                begin
                    stamp_reg[k] <= now_ms;
                end
            end
        end
    end

endmodule

FILE: rtl/kar_serial.sv
// event batch register, hands out pending events lowest key first
module kar_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  kar_pkg::evt_batch_t batch,
    output logic                can_load,
    kar_out_if.source           events
);

    logic [kar_pkg::NUM_KEYS-1:0]  pend_reg;
    logic [kar_pkg::NUM_KEYS-1:0]  pend_next;
    kar_pkg::kind_t [kar_pkg::NUM_KEYS-1:0] kind_reg;
    logic [kar_pkg::NUM_KEYS-1:0]  rest;
    logic [kar_pkg::KEY_BITS-1:0]  first_key;
    logic                          xfer;

    always_comb
    begin
        first_key = '0;
        for (int k = kar_pkg::NUM_KEYS - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                first_key = kar_pkg::KEY_BITS'(k);
            end
        end
    end

    // pending set with its lowest bit removed
    assign rest = pend_reg & (pend_reg - kar_pkg::NUM_KEYS'(1));

    assign events.valid       = |pend_reg;
    assign events.key_index   = first_key;
    assign events.event_kind  = kind_reg[first_key];
    assign events.last_of_run = (rest == '0);

    assign xfer     = events.valid && events.ready;
    assign can_load = !events.valid || (xfer && rest == '0);

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            pend_next = batch.mask;
        end
        else if (xfer)
        begin
            pend_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= batch.kind;
        end
    end

endmodule

FILE: rtl/key_auto_repeat_events.sv
// typematic auto repeat for four keys: press, repeat and release events
//
// items channel: one transfer per sample, a millisecond timestamp and the
// debounced key levels. events channel: one transfer per event, keys in the
// order up, down, back, ok, with last_of_run set on the final event of a
// sample. a sample that causes no event produces no transfer.
// the key state is updated in the cycle a sample is taken, and its events
// sit in an output register from the next cycle on, one per cycle while the
// receiver is ready.
// a new sample is taken when the event register is empty or its final event
// transfers in the same cycle; events ready thus reaches items ready.
// when the receiver stalls the current event holds and no sample is taken.
// reset releases all keys, disarms repeat, zeroes the time stamps and loads
// a repeat delay of 500 ms and an interval of 80 ms.
// wr_en/wr_index/wr_data write register 0 (repeat delay) or 1 (interval);
// write them only while no events are pending.
module key_auto_repeat_events (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  kar_pkg::reg_index_t               wr_index,
    input  logic [kar_pkg::CFG_BITS-1:0]      wr_data,
    kar_in_if.sink                            items,
    kar_out_if.source                         events
);

    logic [kar_pkg::CFG_BITS-1:0] delay_reg;
    logic [kar_pkg::CFG_BITS-1:0] interval_reg;
    kar_pkg::evt_batch_t          batch;
    logic                         can_load;
    logic                         fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= kar_pkg::RESET_DELAY;
            interval_reg <= kar_pkg::RESET_INTERVAL;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                kar_pkg::REG_REPEAT_DELAY:    delay_reg    <= wr_data;
                kar_pkg::REG_REPEAT_INTERVAL: interval_reg <= wr_data;
                default:                      delay_reg    <= delay_reg;
            endcase
        end
    end

    assign items.ready = can_load;
    assign fire        = items.valid && can_load;

    kar_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .now_ms    (items.now_ms),
        .keys_down (items.keys_down),
        .delay     (delay_reg),
        .interval  (interval_reg),
        .batch     (batch)
    );

    kar_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .batch    (batch),
        .can_load (can_load),
        .events   (events)
    );

endmodule
